// ----- rtl/ost_pkg.sv -----
// Package for the ordered sequence table: operation codes and sizing constants.
// No dependencies.
`timescale 1ns / 1ps
package ost_pkg;

    localparam int DEF_CAPACITY   = 64;
    localparam int DEF_ITEM_WIDTH = 32;
    localparam int MODE_W         = 3;
    localparam int POS_W          = 7;
    localparam int VALUE_W        = 32;
    localparam int COUNT_W        = 7;

    typedef enum logic [MODE_W-1:0] {
        OP_INSERT_AT     = 3'd0,
        OP_INSERT_SORTED = 3'd1,
        OP_ERASE_AT      = 3'd2,
        OP_REMOVE_ALL    = 3'd3,
        OP_GET           = 3'd4,
        OP_SET           = 3'd5,
        OP_FIND          = 3'd6,
        OP_NONE          = 3'd7
    } op_t;

endpackage

// ----- rtl/ordered_sequence_table.sv -----
// Ordered sequence table: top level with sequencer, item memory and output register.
// Depends on ost_pkg.
`timescale 1ns / 1ps
// One word in, one result word out. Find and insert_sorted scan the held items
// with a read state and a compare state per item; insert, erase and remove_all
// move items with a read state and a write state per entry over the item memory.
// One operation is in flight at a time; a new word is taken while the previous
// result still waits in the output register.
module ordered_sequence_table #(
    parameter int CAPACITY   = ost_pkg::DEF_CAPACITY,
    parameter int ITEM_WIDTH = ost_pkg::DEF_ITEM_WIDTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // mode[2:0], position[9:3], value[41:10], zero fill to 48 bits
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // success[0], result_position[7:1], read_value[39:8], removed_count[46:40],
    // item_count[53:47], is_empty[54], zero fill to 56 bits
    output logic [55:0] m_axis_tdata
);
    import ost_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_SHUP_RD, S_SHUP_WR, S_PUT,
        S_SHDN_RD, S_SHDN_WR, S_REM_RD, S_REM_WR, S_GET_RD, S_GET_WAIT, S_DONE
    } state_t;

    state_t                state_reg;
    op_t                   op_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [ITEM_WIDTH-1:0] val_reg;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         idx_reg;   // read cursor
    logic [CW-1:0]         wix_reg;   // write cursor / target
    logic [CW-1:0]         rem_reg;
    logic                  ok_reg;
    logic [CW-1:0]         rpos_reg;
    logic [ITEM_WIDTH-1:0] rval_reg;

    // item memory, one write port and one registered read port
    logic [ITEM_WIDTH-1:0] mem [CAPACITY];
    logic [ITEM_WIDTH-1:0] rd_data_reg;
    logic                  mem_we;
    logic [AW-1:0]         mem_wa;
    logic [ITEM_WIDTH-1:0] mem_wd;
    logic [AW-1:0]         mem_ra;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[mem_ra];
    end

    logic out_free;
    assign out_free      = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);

    logic [MODE_W-1:0]     in_mode;
    logic [POS_W-1:0]      in_pos;
    logic [ITEM_WIDTH-1:0] in_val;
    assign in_mode = s_axis_tdata[2:0];
    assign in_pos  = s_axis_tdata[9:3];
    assign in_val  = s_axis_tdata[10 +: ITEM_WIDTH];

    // memory port control
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = wix_reg[AW-1:0];
        mem_wd = rd_data_reg;
        mem_ra = idx_reg[AW-1:0];
        unique case (state_reg)
            // fetch the entry just below the cursor
            S_SHUP_RD: mem_ra = AW'(idx_reg - 1'b1);
            // shift-up write lands one above the entry just read
            S_SHUP_WR:
            begin
                mem_we = 1'b1;
                mem_wa = AW'(idx_reg + 1'b1);
            end
            S_SHDN_WR: mem_we = 1'b1;
            S_REM_WR:  mem_we = (rd_data_reg != val_reg);
            S_PUT:
            begin
                mem_we = 1'b1;
                mem_wd = val_reg;
            end
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            m_axis_tvalid <= 1'b0;
            m_axis_tdata  <= '0;
            op_reg        <= OP_NONE;
            pos_reg       <= '0;
            val_reg       <= '0;
            idx_reg       <= '0;
            wix_reg       <= '0;
            rem_reg       <= '0;
            ok_reg        <= 1'b0;
            rpos_reg      <= '0;
            rval_reg      <= '0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready && state_reg != S_DONE)
            begin
                m_axis_tvalid <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        op_reg   <= op_t'(in_mode);
                        pos_reg  <= in_pos;
                        val_reg  <= in_val;
                        ok_reg   <= 1'b0;
                        rpos_reg <= '0;
                        rval_reg <= '0;
                        rem_reg  <= '0;
                        idx_reg  <= '0;
                        wix_reg  <= '0;
                        unique case (op_t'(in_mode))
                            OP_INSERT_AT:
                                if ((CW + 1)'(in_pos) <= (CW + 1)'(count_reg)
                                    && count_reg < CW'(CAPACITY))
                                begin
                                    ok_reg   <= 1'b1;
                                    rpos_reg <= CW'(in_pos);
                                    wix_reg  <= CW'(in_pos);
                                    idx_reg  <= count_reg;
                                    state_reg <= S_SHUP_RD;
                                end
                                else state_reg <= S_DONE;
                            OP_INSERT_SORTED, OP_FIND:
                                if (op_t'(in_mode) == OP_INSERT_SORTED
                                    && count_reg >= CW'(CAPACITY))
                                    state_reg <= S_DONE;
                                else state_reg <= S_SCAN_RD;
                            OP_ERASE_AT:
                                if ((CW + 1)'(in_pos) < (CW + 1)'(count_reg))
                                begin
                                    ok_reg   <= 1'b1;
                                    rpos_reg <= CW'(in_pos);
                                    wix_reg  <= CW'(in_pos);
                                    idx_reg  <= CW'(in_pos) + 1'b1;
                                    state_reg <= S_SHDN_RD;
                                end
                                else state_reg <= S_DONE;
                            OP_REMOVE_ALL: state_reg <= S_REM_RD;
                            OP_GET, OP_SET:
                                if ((CW + 1)'(in_pos) < (CW + 1)'(count_reg))
                                begin
                                    ok_reg   <= 1'b1;
                                    rpos_reg <= CW'(in_pos);
                                    wix_reg  <= CW'(in_pos);
                                    idx_reg  <= CW'(in_pos);
                                    state_reg <= (op_t'(in_mode) == OP_GET) ? S_GET_RD
                                                                            : S_PUT;
                                end
                                else state_reg <= S_DONE;
                            default: state_reg <= S_DONE;
                        endcase
                    end
                end
                // scan for first >= (insert) or == (find)
                S_SCAN_RD:
                begin
                    if (idx_reg >= count_reg)
                    begin
                        if (op_reg == OP_INSERT_SORTED)
                        begin
                            ok_reg   <= 1'b1;
                            rpos_reg <= idx_reg;
                            wix_reg  <= idx_reg;
                            idx_reg  <= count_reg;
                            state_reg <= S_SHUP_RD;
                        end
                        else state_reg <= S_DONE;
                    end
                    else state_reg <= S_SCAN_CMP;
                end
                S_SCAN_CMP:
                begin
                    if (op_reg == OP_INSERT_SORTED && val_reg <= rd_data_reg)
                    begin
                        ok_reg   <= 1'b1;
                        rpos_reg <= idx_reg;
                        wix_reg  <= idx_reg;
                        idx_reg  <= count_reg;
                        state_reg <= S_SHUP_RD;
                    end
                    else if (op_reg == OP_FIND && val_reg == rd_data_reg)
                    begin
                        ok_reg   <= 1'b1;
                        rpos_reg <= idx_reg;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_SCAN_RD;
                    end
                end
                // open gap: move entry idx-1 to idx while idx > target
                S_SHUP_RD:
                begin
                    if (idx_reg > wix_reg)
                    begin
                        idx_reg   <= idx_reg - 1'b1;
                        state_reg <= S_SHUP_WR;
                    end
                    else state_reg <= S_PUT;
                end
                S_SHUP_WR:
                begin
                    // write goes to idx+1 of the read entry
                    state_reg <= S_SHUP_RD;
                end
                S_PUT:
                begin
                    if (op_reg != OP_SET)
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                    state_reg <= S_DONE;
                end
                // close gap: move idx to idx-1
                S_SHDN_RD:
                begin
                    if (idx_reg < count_reg) state_reg <= S_SHDN_WR;
                    else
                    begin
                        count_reg <= count_reg - 1'b1;
                        state_reg <= S_DONE;
                    end
                end
                S_SHDN_WR:
                begin
                    wix_reg   <= wix_reg + 1'b1;
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= S_SHDN_RD;
                end
                // compact: keep entries not equal to the value
                S_REM_RD:
                begin
                    if (idx_reg < count_reg) state_reg <= S_REM_WR;
                    else
                    begin
                        count_reg <= wix_reg;
                        ok_reg    <= (rem_reg != '0);
                        state_reg <= S_DONE;
                    end
                end
                S_REM_WR:
                begin
                    if (rd_data_reg != val_reg) wix_reg <= wix_reg + 1'b1;
                    else rem_reg <= rem_reg + 1'b1;
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= S_REM_RD;
                end
                S_GET_RD:   state_reg <= S_GET_WAIT;
                S_GET_WAIT:
                begin
                    rval_reg  <= rd_data_reg;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        m_axis_tvalid <= 1'b1;
                        m_axis_tdata  <= {1'b0, (count_reg == '0),
                                          POS_W'(count_reg), POS_W'(rem_reg),
                                          VALUE_W'(rval_reg), POS_W'(rpos_reg),
                                          ok_reg};
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- verif/ordered_sequence_table_tb.sv -----
// Testbench for the ordered sequence table: directed table, fill to capacity, then random
// operations, each result checked against an in-bench model of the sequence. Depends on ost_pkg.
`timescale 1ns / 1ps
module ordered_sequence_table_tb;
    import ost_pkg::*;

    localparam int CAP = 64;
    localparam int RANDOM_OPS = 420;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic       is_empty;
        logic [6:0] item_count;
        logic [6:0] removed_count;
        logic [31:0] read_value;
        logic [6:0] result_position;
        logic       success;
    } result_t;

    typedef struct {
        op_t         op;
        logic [6:0]  pos;
        logic [31:0] val;
        logic        has_fixed;
        result_t     fixed;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // mode, position, value, zero fill
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // success, result_position, read_value, removed_count, item_count, is_empty, fill
    logic [55:0] m_axis_tdata;

    ordered_sequence_table u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // model of the sequence
    logic [31:0] seq_items[CAP];
    int          seq_len;
    result_t     pending_results[$];
    int          mismatch_count;
    int          idle_cycles;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // apply one operation to the model, return the result it must produce
    function automatic result_t apply_op(op_t op, logic [6:0] pos, logic [31:0] val);
        result_t r;
        int      i;
        int      kept;
        r = '0;
        case (op)
            OP_INSERT_AT, OP_INSERT_SORTED:
            begin
                if (op == OP_INSERT_SORTED)
                begin
                    for (i = 0; i < seq_len; i++)
                        if (val <= seq_items[i]) break;
                end
                else
                    i = pos;
                if (i <= seq_len && seq_len < CAP)
                begin
                    for (int j = seq_len; j > i; j--) seq_items[j] = seq_items[j-1];
                    seq_items[i] = val;
                    seq_len++;
                    r.success = 1'b1;
                    r.result_position = 7'(i);
                end
            end
            OP_ERASE_AT:
            begin
                if (pos < seq_len)
                begin
                    for (int j = pos; j + 1 < seq_len; j++) seq_items[j] = seq_items[j+1];
                    seq_len--;
                    r.success = 1'b1;
                    r.result_position = pos;
                end
            end
            OP_REMOVE_ALL:
            begin
                kept = 0;
                for (i = 0; i < seq_len; i++)
                    if (seq_items[i] == val) r.removed_count++;
                    else seq_items[kept++] = seq_items[i];
                seq_len = kept;
                r.success = (r.removed_count != 0);
            end
            OP_GET, OP_SET:
            begin
                if (pos < seq_len)
                begin
                    if (op == OP_GET) r.read_value = seq_items[pos];
                    else seq_items[pos] = val;
                    r.success = 1'b1;
                    r.result_position = pos;
                end
            end
            OP_FIND:
            begin
                for (i = 0; i < seq_len; i++)
                    if (seq_items[i] == val)
                    begin
                        r.success = 1'b1;
                        r.result_position = 7'(i);
                        break;
                    end
            end
            default: ;
        endcase
        r.item_count = 7'(seq_len);
        r.is_empty = (seq_len == 0);
        return r;
    endfunction

    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 50) return 0;
        if (k < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    // send one word and queue its expected result
    task automatic send_op(op_t op, logic [6:0] pos, logic [31:0] val,
                           bit has_fixed, result_t fixed);
        result_t r;
        int      g;
        g = gap_len();
        if (g != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        r = apply_op(op, pos, val);
        if (has_fixed && r !== fixed)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("table row disagrees with model: exp %h got %h", fixed, r);
        end
        pending_results.push_back(r);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, val, pos, op};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    // output stall
    initial begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 99) < 3)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(10, 80)) @(posedge clk);
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) < 20) ? 1'b0 : 1'b1;
        end
    end

    // check each result word
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = result_t'(m_axis_tdata[54:0]);
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected result word %h", got);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want || m_axis_tdata[55] !== 1'b0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: exp ok=%0d pos=%0d rd=%h rm=%0d cnt=%0d",
                                  " emp=%0d got ok=%0d pos=%0d rd=%h rm=%0d cnt=%0d",
                                  " emp=%0d"},
                                 want.success, want.result_position, want.read_value,
                                 want.removed_count, want.item_count, want.is_empty,
                                 got.success, got.result_position, got.read_value,
                                 got.removed_count, got.item_count, got.is_empty);
                end
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic result_t mk(bit ok, int p, logic [31:0] rd, int rm, int cnt);
        result_t r;
        r.success = ok;
        r.result_position = 7'(p);
        r.read_value = rd;
        r.removed_count = 7'(rm);
        r.item_count = 7'(cnt);
        r.is_empty = (cnt == 0);
        return r;
    endfunction

    initial begin
        row_t    rows[$];
        op_t     op;
        logic [6:0]  pos;
        logic [31:0] val;
        int      k;
        result_t none;
        none = '0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        seq_len = 0;
        mismatch_count = 0;
        idle_cycles = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows; fixed results only where obvious
        rows.push_back('{OP_GET, 7'd0, 32'd0, 1, mk(0, 0, 0, 0, 0)});
        rows.push_back('{OP_ERASE_AT, 7'd0, 32'd0, 1, mk(0, 0, 0, 0, 0)});
        rows.push_back('{OP_SET, 7'd0, 32'd5, 1, mk(0, 0, 0, 0, 0)});
        rows.push_back('{OP_FIND, 7'd0, 32'd0, 1, mk(0, 0, 0, 0, 0)});
        rows.push_back('{OP_REMOVE_ALL, 7'd0, 32'd0, 1, mk(0, 0, 0, 0, 0)});
        rows.push_back('{OP_NONE, 7'h7f, 32'hffffffff, 1, mk(0, 0, 0, 0, 0)});
        rows.push_back('{OP_INSERT_AT, 7'd1, 32'd1, 1, mk(0, 0, 0, 0, 0)});
        rows.push_back('{OP_INSERT_AT, 7'd0, 32'hffffffff, 1, mk(1, 0, 0, 0, 1)});
        rows.push_back('{OP_INSERT_SORTED, 7'd0, 32'd0, 1, mk(1, 0, 0, 0, 2)});
        rows.push_back('{OP_INSERT_SORTED, 7'd0, 32'h8000_0000, 0, none});
        rows.push_back('{OP_GET, 7'd2, 32'd0, 1, mk(1, 2, 32'hffffffff, 0, 3)});
        rows.push_back('{OP_GET, 7'd3, 32'd0, 1, mk(0, 0, 0, 0, 3)});
        rows.push_back('{OP_INSERT_AT, 7'd3, 32'd0, 0, none});
        rows.push_back('{OP_SET, 7'd1, 32'hffffffff, 0, none});
        rows.push_back('{OP_FIND, 7'h55, 32'hffffffff, 0, none});
        rows.push_back('{OP_REMOVE_ALL, 7'h2a, 32'hffffffff, 0, none});
        rows.push_back('{OP_ERASE_AT, 7'h7f, 32'd0, 1, mk(0, 0, 0, 0, 2)});
        rows.push_back('{OP_ERASE_AT, 7'd1, 32'd0, 0, none});
        rows.push_back('{OP_REMOVE_ALL, 7'd0, 32'd0, 0, none});
        foreach (rows[i])
            send_op(rows[i].op, rows[i].pos, rows[i].val, rows[i].has_fixed, rows[i].fixed);

        // fill to capacity, then refused inserts while full and gets at the last and one past the last position
        while (seq_len < CAP)
            send_op(OP_INSERT_SORTED, 7'(seq_len), 32'($urandom_range(0, 15)), 0, none);
        send_op(OP_INSERT_AT, 7'd0, 32'd1, 0, none);
        send_op(OP_INSERT_SORTED, 7'd0, 32'd1, 0, none);
        send_op(OP_GET, 7'd63, 32'd0, 0, none);
        send_op(OP_GET, 7'd64, 32'd0, 0, none);

        // random operations over a small value alphabet so finds and removes hit
        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            k = $urandom_range(0, 99);
            if (k < 25) op = (seq_len < 40) ? OP_INSERT_AT : OP_ERASE_AT;
            else op = op_t'($urandom_range(0, 7));
            if ($urandom_range(0, 9) == 0) pos = 7'($urandom);
            else pos = 7'($urandom_range(0, seq_len));
            if ($urandom_range(0, 3) == 0) val = $urandom;
            else val = 32'($urandom_range(0, 7)) ^ {32{$urandom_range(0, 1) == 1}};
            send_op(op, pos, val, 0, none);
        end

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
